FILE: rtl/segi_pkg.sv
// Package with the payload types and fixed widths of the segment intersection block.
`default_nettype none
package segi_pkg;

  // Coordinate width, Q12.4 two's complement
  localparam int COORD_W = 16;
  // Segment vector components: difference of two coordinates
  localparam int DIFF_W  = COORD_W + 1;
  // One product of two vector components
  localparam int PROD_W  = 2 * DIFF_W;
  // Cross product: difference of two products
  localparam int CROSS_W = PROD_W + 1;
  // Dividend magnitude: vector component times cross product
  localparam int NUM_W   = DIFF_W + CROSS_W;
  // Quotient magnitude never exceeds a vector component magnitude
  localparam int QUOT_W  = COORD_W;

  typedef struct packed {
    logic signed [COORD_W-1:0] seg_a_start_x;
    logic signed [COORD_W-1:0] seg_a_start_y;
    logic signed [COORD_W-1:0] seg_a_end_x;
    logic signed [COORD_W-1:0] seg_a_end_y;
    logic signed [COORD_W-1:0] seg_b_start_x;
    logic signed [COORD_W-1:0] seg_b_start_y;
    logic signed [COORD_W-1:0] seg_b_end_x;
    logic signed [COORD_W-1:0] seg_b_end_y;
  } seg_in_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] cross_x;
    logic signed [COORD_W-1:0] cross_y;
  } seg_out_t;

endpackage
`default_nettype wire

FILE: rtl/segi_div.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
`default_nettype none
module segi_div
  import segi_pkg::*;
#(
  parameter int NW = 52,
  parameter int DW = 35,
  parameter int QW = 16,
  parameter int SW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  wire logic          in_neg,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [QW-1:0]      out_quot,
  output logic               out_neg,
  output logic [SW-1:0]      out_side
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic          v_s    [QW+1];
  logic [CW-1:0] num_s  [QW+1];
  logic [DW-1:0] den_s  [QW+1];
  logic [QW-1:0] q_s    [QW+1];
  logic          neg_s  [QW+1];
  logic [SW-1:0] side_s [QW+1];

  assign v_s[0]    = in_valid;
  assign num_s[0]  = CW'(in_num);
  assign den_s[0]  = in_den;
  assign q_s[0]    = '0;
  assign neg_s[0]  = in_neg;
  assign side_s[0] = in_side;

  for (genvar g = 0; g < QW; g++) begin : g_stage
    localparam int B = QW - 1 - g;

    logic          v_r;
    logic [CW-1:0] num_r;
    logic [DW-1:0] den_r;
    logic [QW-1:0] q_r;
    logic          neg_r;
    logic [SW-1:0] side_r;
    logic [CW-1:0] trial;
    logic          fits;
    logic [CW-1:0] num_nxt;
    logic [QW-1:0] q_nxt;

    // Try the divisor shifted to this quotient bit, subtract when it fits
    always_comb begin
      trial   = CW'(den_s[g]) << B;
      fits    = num_s[g] >= trial;
      num_nxt = fits ? (num_s[g] - trial) : num_s[g];
      q_nxt   = q_s[g];
      q_nxt[B] = fits;
    end

    // Advance the stage when the pipe moves
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_s[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r  <= num_nxt;
        den_r  <= den_s[g];
        q_r    <= q_nxt;
        neg_r  <= neg_s[g];
        side_r <= side_s[g];
      end
    end

    assign v_s[g+1]    = v_r;
    assign num_s[g+1]  = num_r;
    assign den_s[g+1]  = den_r;
    assign q_s[g+1]    = q_r;
    assign neg_s[g+1]  = neg_r;
    assign side_s[g+1] = side_r;
  end

  assign out_valid = v_s[QW];
  assign out_quot  = q_s[QW];
  assign out_neg   = neg_s[QW];
  assign out_side  = side_s[QW];

endmodule
`default_nettype wire

FILE: rtl/segment_intersection.sv
// Throughput: one segment pair per cycle; the two dividers take one quotient bit per stage.
// The whole pipeline holds while a finished result waits under out_stall.
// Reset (rst_n low, synchronous) clears every stage valid bit and the output valid.
// Payload registers are not reset.
// Top level: 2D segment intersection test with crossing point.
`default_nettype none
module segment_intersection
  import segi_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire seg_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output seg_out_t      out_data
);

  logic en;

  // Move the whole pipe unless a held result blocks the output
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 1: segment vectors
  logic                     s1_v_r;
  logic signed [DIFF_W-1:0] s1_bx_r, s1_by_r, s1_dx_r, s1_dy_r, s1_cx_r, s1_cy_r;
  logic signed [COORD_W-1:0] s1_ax_r, s1_ay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_bx_r <= DIFF_W'(in_data.seg_a_end_x) - DIFF_W'(in_data.seg_a_start_x);
      s1_by_r <= DIFF_W'(in_data.seg_a_end_y) - DIFF_W'(in_data.seg_a_start_y);
      s1_dx_r <= DIFF_W'(in_data.seg_b_end_x) - DIFF_W'(in_data.seg_b_start_x);
      s1_dy_r <= DIFF_W'(in_data.seg_b_end_y) - DIFF_W'(in_data.seg_b_start_y);
      s1_cx_r <= DIFF_W'(in_data.seg_b_start_x) - DIFF_W'(in_data.seg_a_start_x);
      s1_cy_r <= DIFF_W'(in_data.seg_b_start_y) - DIFF_W'(in_data.seg_a_start_y);
      s1_ax_r <= in_data.seg_a_start_x;
      s1_ay_r <= in_data.seg_a_start_y;
    end
  end

  // Stage 2: the six products of the cross products
  logic                      s2_v_r;
  logic signed [PROD_W-1:0]  s2_bdy_r, s2_bydx_r, s2_cdy_r, s2_cydx_r, s2_cby_r, s2_cybx_r;
  logic signed [DIFF_W-1:0]  s2_bx_r, s2_by_r;
  logic signed [COORD_W-1:0] s2_ax_r, s2_ay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_bdy_r  <= PROD_W'(s1_bx_r) * PROD_W'(s1_dy_r);
      s2_bydx_r <= PROD_W'(s1_by_r) * PROD_W'(s1_dx_r);
      s2_cdy_r  <= PROD_W'(s1_cx_r) * PROD_W'(s1_dy_r);
      s2_cydx_r <= PROD_W'(s1_cy_r) * PROD_W'(s1_dx_r);
      s2_cby_r  <= PROD_W'(s1_cx_r) * PROD_W'(s1_by_r);
      s2_cybx_r <= PROD_W'(s1_cy_r) * PROD_W'(s1_bx_r);
      s2_bx_r   <= s1_bx_r;
      s2_by_r   <= s1_by_r;
      s2_ax_r   <= s1_ax_r;
      s2_ay_r   <= s1_ay_r;
    end
  end

  // Stage 3: denominator and the two parameter numerators
  logic                      s3_v_r;
  logic signed [CROSS_W-1:0] s3_den_r, s3_tnum_r, s3_unum_r;
  logic signed [DIFF_W-1:0]  s3_bx_r, s3_by_r;
  logic signed [COORD_W-1:0] s3_ax_r, s3_ay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_den_r  <= CROSS_W'(s2_bdy_r) - CROSS_W'(s2_bydx_r);
      s3_tnum_r <= CROSS_W'(s2_cdy_r) - CROSS_W'(s2_cydx_r);
      s3_unum_r <= CROSS_W'(s2_cby_r) - CROSS_W'(s2_cybx_r);
      s3_bx_r   <= s2_bx_r;
      s3_by_r   <= s2_by_r;
      s3_ax_r   <= s2_ax_r;
      s3_ay_r   <= s2_ay_r;
    end
  end

  // Stage 4: range test on both parameters, scale the A vector by tnum
  logic t_in, u_in, s4_hit_nxt;

  always_comb begin
    if (s3_den_r > 0) begin
      t_in = (s3_tnum_r >= 0) && (s3_tnum_r <= s3_den_r);
      u_in = (s3_unum_r >= 0) && (s3_unum_r <= s3_den_r);
    end else begin
      t_in = (s3_tnum_r <= 0) && (s3_tnum_r >= s3_den_r);
      u_in = (s3_unum_r <= 0) && (s3_unum_r >= s3_den_r);
    end
    s4_hit_nxt = (s3_den_r != 0) && t_in && u_in;
  end

  logic                      s4_v_r, s4_hit_r;
  logic signed [NUM_W-1:0]   s4_nx_r, s4_ny_r;
  logic signed [CROSS_W-1:0] s4_den_r;
  logic signed [COORD_W-1:0] s4_ax_r, s4_ay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_hit_r <= s4_hit_nxt;
      s4_nx_r  <= NUM_W'(s3_bx_r) * NUM_W'(s3_tnum_r);
      s4_ny_r  <= NUM_W'(s3_by_r) * NUM_W'(s3_tnum_r);
      s4_den_r <= s3_den_r;
      s4_ax_r  <= s3_ax_r;
      s4_ay_r  <= s3_ay_r;
    end
  end

  // Stage 5: magnitudes and quotient signs for the dividers
  logic                      s5_v_r, s5_hit_r, s5_negx_r, s5_negy_r;
  logic [NUM_W-1:0]          s5_nx_r, s5_ny_r;
  logic [CROSS_W-1:0]        s5_den_r;
  logic signed [COORD_W-1:0] s5_ax_r, s5_ay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_hit_r  <= s4_hit_r;
      s5_nx_r   <= s4_nx_r[NUM_W-1] ? NUM_W'(-s4_nx_r) : NUM_W'(s4_nx_r);
      s5_ny_r   <= s4_ny_r[NUM_W-1] ? NUM_W'(-s4_ny_r) : NUM_W'(s4_ny_r);
      s5_den_r  <= s4_den_r[CROSS_W-1] ? CROSS_W'(-s4_den_r) : CROSS_W'(s4_den_r);
      s5_negx_r <= s4_nx_r[NUM_W-1] ^ s4_den_r[CROSS_W-1];
      s5_negy_r <= s4_ny_r[NUM_W-1] ^ s4_den_r[CROSS_W-1];
      s5_ax_r   <= s4_ax_r;
      s5_ay_r   <= s4_ay_r;
    end
  end

  // Dividers, one per axis
  logic               dx_v, dy_v, dx_neg, dy_neg;
  logic [QUOT_W-1:0]  dx_q, dy_q;
  logic [COORD_W:0]   dx_side;
  logic [COORD_W-1:0] dy_side;

  segi_div #(
    .NW(NUM_W), .DW(CROSS_W), .QW(QUOT_W), .SW(COORD_W + 1)
  ) u_div_x (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s5_v_r), .in_num(s5_nx_r), .in_den(s5_den_r), .in_neg(s5_negx_r),
    .in_side({s5_hit_r, s5_ax_r}),
    .out_valid(dx_v), .out_quot(dx_q), .out_neg(dx_neg), .out_side(dx_side)
  );

  segi_div #(
    .NW(NUM_W), .DW(CROSS_W), .QW(QUOT_W), .SW(COORD_W)
  ) u_div_y (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s5_v_r), .in_num(s5_ny_r), .in_den(s5_den_r), .in_neg(s5_negy_r),
    .in_side(s5_ay_r),
    .out_valid(dy_v), .out_quot(dy_q), .out_neg(dy_neg), .out_side(dy_side)
  );

  // Output stage: add the signed offset to the A start, zero on a miss
  logic             fin_hit;
  logic [COORD_W:0] offx, offy, sumx, sumy;
  seg_out_t         out_nxt;

  always_comb begin
    fin_hit = dx_side[COORD_W];
    offx    = dx_neg ? (COORD_W+1)'(-{1'b0, dx_q}) : {1'b0, dx_q};
    offy    = dy_neg ? (COORD_W+1)'(-{1'b0, dy_q}) : {1'b0, dy_q};
    sumx    = {dx_side[COORD_W-1], dx_side[COORD_W-1:0]} + offx;
    sumy    = {dy_side[COORD_W-1], dy_side} + offy;
    out_nxt.hit     = fin_hit;
    out_nxt.cross_x = fin_hit ? sumx[COORD_W-1:0] : '0;
    out_nxt.cross_y = fin_hit ? sumy[COORD_W-1:0] : '0;
  end

  logic     out_valid_r;
  seg_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dx_v && dy_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // A miss always reports the origin
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |-> (out_data.cross_x == 0 && out_data.cross_y == 0))
    else $error("miss result with nonzero point");

  // An input transfer lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_v_r)
    else $error("transferred item lost at entry");

  // Both axis dividers stay in lockstep
  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    dx_v == dy_v)
    else $error("divider valid bits disagree");

  // A held result keeps the first stage frozen
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(s1_v_r))
    else $error("pipeline moved during output stall");
`endif

endmodule
`default_nettype wire

FILE: dv/segi_checker.sv
// Checker for the segment intersection block: predicts each crossing and compares results.
module segi_checker
  import segi_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_stall,
  input  wire seg_in_t  in_data,
  input  wire logic     out_valid,
  input  wire logic     out_stall,
  input  wire seg_out_t out_data,
  output int            fail_count,
  output int            pending
);

  seg_out_t crossings_q[$];

  // Exact test that num/den lies in [0,1]
  function automatic bit in_unit_range(longint num, longint den);
    if (den > 0) return (num >= 0) && (num <= den);
    return (num <= 0) && (num >= den);
  endfunction

  // Compute the expected crossing for one segment pair
  function automatic seg_out_t predict_crossing(seg_in_t s);
    longint ax, ay, bx, by, dx, dy, cx, cy, den, tnum, unum;
    seg_out_t r;
    ax = longint'(s.seg_a_start_x);
    ay = longint'(s.seg_a_start_y);
    bx = longint'(s.seg_a_end_x) - ax;
    by = longint'(s.seg_a_end_y) - ay;
    dx = longint'(s.seg_b_end_x) - longint'(s.seg_b_start_x);
    dy = longint'(s.seg_b_end_y) - longint'(s.seg_b_start_y);
    cx = longint'(s.seg_b_start_x) - ax;
    cy = longint'(s.seg_b_start_y) - ay;
    den  = bx * dy - by * dx;
    tnum = cx * dy - cy * dx;
    unum = cx * by - cy * bx;
    r = '0;
    if (den != 0 && in_unit_range(tnum, den) && in_unit_range(unum, den)) begin
      r.hit = 1'b1;
      r.cross_x = COORD_W'(ax + (bx * tnum) / den);
      r.cross_y = COORD_W'(ay + (by * tnum) / den);
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("segi_checker: mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = crossings_q.size();

  // Queue a prediction per input transfer, compare per output transfer
  always @(posedge clk) begin
    seg_out_t exp_r;
    if (rst_n) begin
      if (in_valid && !in_stall) crossings_q.push_back(predict_crossing(in_data));
      if (out_valid && !out_stall) begin
        if (crossings_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          exp_r = crossings_q.pop_front();
          if (out_data.hit !== exp_r.hit)
            report_mismatch($sformatf("hit %b exp %b", out_data.hit, exp_r.hit));
          if (out_data.cross_x !== exp_r.cross_x)
            report_mismatch($sformatf("cross_x %0d exp %0d", out_data.cross_x,
                                      exp_r.cross_x));
          if (out_data.cross_y !== exp_r.cross_y)
            report_mismatch($sformatf("cross_y %0d exp %0d", out_data.cross_y,
                                      exp_r.cross_y));
        end
      end
    end
  end

endmodule

FILE: dv/tb_segment_intersection.sv
// Testbench top for the segment intersection block: stimulus, stalls and verdict.
module tb_segment_intersection;
  import segi_pkg::*;

  localparam int LATENCY = COORD_W + 6;
  localparam int CYCLE_LIMIT = 200000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  seg_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  seg_out_t out_data;
  int       fail_count;
  int       pending;
  int       cycle_count = 0;
  bit       hold_off = 1'b0;

  segment_intersection dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  segi_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  // End the run at the cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_segment_intersection: done, errors");
      $finish;
    end
  end

  // Receiver stall pattern: random phases, calm stretches, and one long hold-off
  initial begin
    int mode;
    int len;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (3 * LATENCY) @(posedge clk);
        hold_off = 1'b0;
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(1, 40);
      repeat (len) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Offer one pair and hold it until transferred
  task automatic send_pair(seg_in_t s);
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord(int span);
    case ($urandom_range(0, 5))
      0: return COORD_W'($urandom());
      1: return COORD_W'({$urandom_range(0, 1)} ? 32'h8000 : 32'h7fff);
      default: return COORD_W'($urandom_range(0, 2 * span) - span);
    endcase
  endfunction

  function automatic seg_in_t make_pair(int a0, int a1, int a2, int a3,
                                        int b0, int b1, int b2, int b3);
    seg_in_t s;
    s.seg_a_start_x = COORD_W'(a0); s.seg_a_start_y = COORD_W'(a1);
    s.seg_a_end_x = COORD_W'(a2);   s.seg_a_end_y = COORD_W'(a3);
    s.seg_b_start_x = COORD_W'(b0); s.seg_b_start_y = COORD_W'(b1);
    s.seg_b_end_x = COORD_W'(b2);   s.seg_b_end_y = COORD_W'(b3);
    return s;
  endfunction

  initial begin
    seg_in_t s;
    int span;
    int gap;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: crossings, parallel, collinear, endpoint touches, extremes
    send_pair(make_pair(0, 0, 160, 160, 0, 160, 160, 0));
    send_pair(make_pair(0, 0, 160, 0, 0, 16, 160, 16));
    send_pair(make_pair(0, 0, 160, 0, 32, 0, 320, 0));
    send_pair(make_pair(0, 0, 160, 0, 160, 0, 160, 160));
    send_pair(make_pair(0, 0, 160, 0, 0, -80, 0, 80));
    send_pair(make_pair(0, 0, 160, 0, 170, -80, 170, 80));
    send_pair(make_pair(0, 0, 160, 160, 0, 0, 0, 0));
    send_pair(make_pair(5, 7, 5, 7, 5, 7, 5, 7));
    send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    send_pair(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
    send_pair(make_pair(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767));
    send_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    send_pair(make_pair(3, 1, -7, 5, -3, -3, 4, 9));
    send_pair(make_pair(0, 0, 100, 33, 100, 0, 0, 33));
    s = '1; send_pair(s);
    s = '0; send_pair(s);

    // Random: mostly crossing-prone pairs at various scales, some raw noise
    for (int i = 0; i < 1600; i++) begin
      if (i == 400) hold_off = 1'b1;
      span = ($urandom_range(0, 1)) ? 64 : 32767;
      if ($urandom_range(0, 9) == 0) begin
        s = {$urandom(), $urandom(), $urandom(), $urandom()};
      end else begin
        s.seg_a_start_x = rand_coord(span); s.seg_a_start_y = rand_coord(span);
        s.seg_a_end_x = -s.seg_a_start_x;   s.seg_a_end_y = -s.seg_a_start_y;
        s.seg_b_start_x = rand_coord(span); s.seg_b_start_y = rand_coord(span);
        s.seg_b_end_x = -s.seg_b_start_x;   s.seg_b_end_y = -s.seg_b_start_y;
        if ($urandom_range(0, 2) == 0) s.seg_a_end_x = rand_coord(span);
        if ($urandom_range(0, 2) == 0) s.seg_b_end_y = rand_coord(span);
        if ($urandom_range(0, 7) == 0) s.seg_b_start_x = s.seg_a_start_x;
      end
      send_pair(s);
      // Burst gaps
      if ($urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // Drain, then let the pipeline settle
    while (pending != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_segment_intersection: done, clean");
    end else begin
      $display("tb_segment_intersection: done, errors");
    end
    $finish;
  end

endmodule

FILE: segment_intersection.f
rtl/segi_pkg.sv
rtl/segi_div.sv
rtl/segment_intersection.sv
dv/segi_checker.sv
dv/tb_segment_intersection.sv
